### rtl/mtkg_pkg.sv
package mtkg_pkg;

  localparam int WORD_W     = 32;
  localparam int CNT_W      = 10;
  localparam int RING_DEPTH = 624;
  localparam int FAR_TAP    = 397;

  localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_WRAP   = CNT_W'(RING_DEPTH);
  localparam logic [CNT_W-1:0] CNT_REMIX  = CNT_W'(RING_DEPTH + 1);

  localparam logic [WORD_W-1:0] FILL_SEED    = 32'd19650218;
  localparam logic [WORD_W-1:0] MUL_FILL     = 32'd1812433253;
  localparam logic [WORD_W-1:0] MUL_KEY      = 32'd1664525;
  localparam logic [WORD_W-1:0] MUL_IDX      = 32'd1566083941;
  localparam logic [WORD_W-1:0] HEAD_WORD    = 32'h8000_0000;
  localparam logic [WORD_W-1:0] MATRIX_A     = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] LAST_MIX_IDX = 32'd1;

  // Configuration register byte addresses
  localparam int ADDR_W = 2;
  localparam logic [ADDR_W-1:0] ADDR_SEED_KEY = 2'd0;

  // What the shared step datapath computes for the word entering the ring tail
  typedef enum logic [2:0] {
    OP_FILL_FIRST,
    OP_FILL,
    OP_ROTATE,
    OP_MIX_KEY,
    OP_COPY,
    OP_MIX_IDX,
    OP_MIX_LAST,
    OP_TWIST
  } step_op_t;

  typedef struct packed {
    logic shift;     // advance every cell by one place
    logic fix_head;  // load the two head cells in place, no advance
  } ring_ctl_t;

  typedef struct packed {
    logic [WORD_W-1:0] head;
    logic [WORD_W-1:0] next;
    logic [WORD_W-1:0] far;
    logic [WORD_W-1:0] tail;
  } ring_taps_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] t;
    t = w ^ (w >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

endpackage

### rtl/mtkg_cell.sv
module mtkg_cell
  import mtkg_pkg::*;
(
  input  logic              clk,
  input  logic              shift_en,
  input  logic              load_en,
  input  logic [WORD_W-1:0] in_word,
  input  logic [WORD_W-1:0] load_word,
  output logic [WORD_W-1:0] word_r
);

  logic [WORD_W-1:0] word_nxt;

  always_comb begin
    priority if (load_en) begin
      word_nxt = load_word;
    end else if (shift_en) begin
      word_nxt = in_word;
    end else begin
      word_nxt = word_r;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

### rtl/mtkg_ring.sv
module mtkg_ring
  import mtkg_pkg::*;
(
  input  logic              clk,
  input  ring_ctl_t         ctl,
  input  logic [WORD_W-1:0] tail_word,
  output ring_taps_t        taps
);

  logic [WORD_W-1:0] words [RING_DEPTH];

  genvar i;
  generate
    for (i = 0; i < RING_DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] in_word;
      logic              load_en;
      logic [WORD_W-1:0] load_word;

      if (i == RING_DEPTH - 1) begin : g_tail
        assign in_word = tail_word;
      end else begin : g_body
        assign in_word = words[i+1];
      end

      // head cells take the closing fix-up of seeding in place
      if (i == 0) begin : g_head
        assign load_en   = ctl.fix_head;
        assign load_word = HEAD_WORD;
      end else if (i == 1) begin : g_second
        assign load_en   = ctl.fix_head;
        assign load_word = tail_word;
      end else begin : g_plain
        assign load_en   = 1'b0;
        assign load_word = '0;
      end

      mtkg_cell u_cell (
        .clk       (clk),
        .shift_en  (ctl.shift),
        .load_en   (load_en),
        .in_word   (in_word),
        .load_word (load_word),
        .word_r    (words[i])
      );
    end
  endgenerate

  assign taps.head = words[0];
  assign taps.next = words[1];
  assign taps.far  = words[FAR_TAP];
  assign taps.tail = words[RING_DEPTH-1];

endmodule

### rtl/mtkg_step.sv
module mtkg_step
  import mtkg_pkg::*;
(
  input  step_op_t          op,
  input  ring_taps_t        taps,
  input  logic [WORD_W-1:0] seed_key,
  input  logic [CNT_W-1:0]  cnt,
  output logic [WORD_W-1:0] new_word
);

  logic [WORD_W-1:0] fold;
  logic [WORD_W-1:0] mul_c;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] cnt_ext;
  logic [WORD_W-1:0] y;

  // one shared multiplier, always fed from the word last inserted
  assign fold    = taps.tail ^ (taps.tail >> 30);
  assign prod    = fold * mul_c;
  assign cnt_ext = {{(WORD_W-CNT_W){1'b0}}, cnt};
  assign y       = {taps.head[WORD_W-1], taps.next[WORD_W-2:0]};

  always_comb begin
    unique case (op)
      OP_FILL, OP_FILL_FIRST: mul_c = MUL_FILL;
      OP_MIX_KEY:             mul_c = MUL_KEY;
      default:                mul_c = MUL_IDX;
    endcase
  end

  always_comb begin
    unique case (op)
      OP_FILL_FIRST: new_word = FILL_SEED;
      OP_FILL:       new_word = prod + cnt_ext;
      OP_ROTATE:     new_word = taps.head;
      OP_MIX_KEY:    new_word = (taps.head ^ prod) + seed_key;
      OP_COPY:       new_word = taps.tail;
      OP_MIX_IDX:    new_word = (taps.head ^ prod) - cnt_ext;
      OP_MIX_LAST:   new_word = (taps.next ^ prod) - LAST_MIX_IDX;
      OP_TWIST:      new_word = taps.far ^ (y >> 1) ^ (y[0] ? MATRIX_A : '0);
      default:       new_word = taps.head;
    endcase
  end

endmodule

### rtl/mt19937_single_key_generator_core.sv
// Channel  | Ports                                  | Beat
// ---------+----------------------------------------+-----------------------------------
// input    | in_valid, in_stall, in_restart         | one draw request, restart flag
// output   | out_valid, out_stall, out_random_word  | one tempered 32-bit word
// config   | psel, penable, pwrite, paddr, pwdata,  | seed_key at byte address 0
//          | prdata, pready                         |
//
// Running: one beat in and one word out per cycle while the output is not stalled; the word at the ring head is
// twisted, shifted to the tail and tempered into the output register.
// Seeding after reset or a restart beat: fill, rotate, key mix and index mix passes
// through the cell ring, one dependent multiply per cycle.
// A restart beat then gets its word from the S_DRAW step that follows seeding.
// in_stall stays high during seeding and that draw, and while a held output word is stalled.
module mt19937_single_key_generator_core
  import mtkg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_restart,

  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_random_word,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0] pwdata,
  output logic [WORD_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [2:0] {
    S_FILL,
    S_ROTATE,
    S_MIX_KEY,
    S_MIX_IDX,
    S_DRAW,
    S_RUN
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic [WORD_W-1:0] seed_r, seed_nxt;

  step_op_t          op;
  ring_ctl_t         ring_ctl;
  ring_taps_t        taps;
  logic [WORD_W-1:0] new_word;
  logic              in_acc;
  logic              out_acc;
  logic              cfg_wr;

  // ---------------------------------------------------------------------------
  // Configuration: a single key register, read back as written
  // ---------------------------------------------------------------------------
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr == ADDR_SEED_KEY);
  assign seed_nxt = cfg_wr ? pwdata : seed_r;
  assign prdata   = (paddr == ADDR_SEED_KEY) ? seed_r : '0;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign in_stall        = (state_r != S_RUN) || (out_valid_r && out_stall);
  assign in_acc          = in_valid && !in_stall;
  assign out_acc         = out_valid_r && !out_stall;
  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  // ---------------------------------------------------------------------------
  // Sequencer: walks the seeding passes, then serves draws.
  // The ring keeps word k of the state at cell 0 once seeded; every draw twists
  // cell 0 against cells 1 and FAR_TAP and pushes the result in at the tail,
  // which matches regenerating the whole block and reading it in order.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    op             = OP_TWIST;
    ring_ctl.shift    = 1'b0;
    ring_ctl.fix_head = 1'b0;
    out_word_nxt   = out_word_r;
    out_valid_nxt  = out_acc ? 1'b0 : out_valid_r;

    unique case (state_r)
      S_FILL: begin
        // linear fill; the first beat plants the fixed start value
        op             = (cnt_r == '0) ? OP_FILL_FIRST : OP_FILL;
        ring_ctl.shift = 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_ROTATE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_ROTATE: begin
        // bring word 1 to the head with word 0 behind it at the tail
        op             = OP_ROTATE;
        ring_ctl.shift = 1'b1;
        cnt_nxt        = CNT_W'(1);
        state_nxt      = S_MIX_KEY;
      end
      S_MIX_KEY: begin
        // words 1..623, then word 0 takes a copy of word 623, then word 1 again
        op             = (cnt_r == CNT_WRAP) ? OP_COPY : OP_MIX_KEY;
        ring_ctl.shift = 1'b1;
        if (cnt_r == CNT_REMIX) begin
          cnt_nxt   = CNT_W'(2);
          state_nxt = S_MIX_IDX;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MIX_IDX: begin
        // words 2..623 shift through; the last step rewrites word 1 in place
        // and forces word 0, which leaves the ring aligned for drawing
        if (cnt_r == CNT_WRAP) begin
          op                = OP_MIX_LAST;
          ring_ctl.fix_head = 1'b1;
          state_nxt         = pend_r ? S_DRAW : S_RUN;
        end else begin
          op             = OP_MIX_IDX;
          ring_ctl.shift = 1'b1;
          cnt_nxt        = cnt_r + 1'b1;
        end
      end
      S_DRAW: begin
        // draw owed to the restart beat; the output register is empty here
        op             = OP_TWIST;
        ring_ctl.shift = 1'b1;
        out_word_nxt   = temper(new_word);
        out_valid_nxt  = 1'b1;
        pend_nxt       = 1'b0;
        state_nxt      = S_RUN;
      end
      S_RUN: begin
        if (in_acc) begin
          if (in_restart) begin
            cnt_nxt   = '0;
            pend_nxt  = 1'b1;
            state_nxt = S_FILL;
          end else begin
            op             = OP_TWIST;
            ring_ctl.shift = 1'b1;
            out_word_nxt   = temper(new_word);
            out_valid_nxt  = 1'b1;
          end
        end
      end
      default: begin
        cnt_nxt   = '0;
        state_nxt = S_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      seed_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      seed_r      <= seed_nxt;
    end
    out_word_r <= out_word_nxt;
  end

  // ---------------------------------------------------------------------------
  // Datapath: one step unit feeding the ring tail, ring of word cells
  // ---------------------------------------------------------------------------
  mtkg_step u_step (
    .op       (op),
    .taps     (taps),
    .seed_key (seed_r),
    .cnt      (cnt_r),
    .new_word (new_word)
  );

  mtkg_ring u_ring (
    .clk       (clk),
    .ctl       (ring_ctl),
    .tail_word (new_word),
    .taps      (taps)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_restart_clears_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_restart) |=> !out_valid)
    else $error("output still valid after a restart beat was taken");

  a_draw_yields_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_restart) |=> out_valid)
    else $error("draw beat produced no output word");

  a_owed_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAW) |=> (out_valid && state_r == S_RUN))
    else $error("restart draw not delivered after seeding");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_REMIX)
    else $error("seeding counter out of range");

  a_head_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MIX_IDX && cnt_r == CNT_WRAP) |=> (taps.head == HEAD_WORD))
    else $error("ring head not forced at end of seeding");

endmodule

### dv/tb_top.sv
module tb_top;
  import mtkg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Generator constants, kept local so the prediction does not lean on the package
  localparam int          MT_N        = 624;
  localparam int          MT_M        = 397;
  localparam logic [31:0] LINEAR_BASE = 32'd19650218;
  localparam logic [31:0] LINEAR_MUL  = 32'd1812433253;
  localparam logic [31:0] KEY_MUL     = 32'd1664525;
  localparam logic [31:0] INDEX_MUL   = 32'd1566083941;
  localparam logic [31:0] TOP_BIT     = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS    = 32'h7fff_ffff;
  localparam logic [31:0] TWIST_XOR   = 32'h9908_b0df;
  localparam logic [31:0] MASK_B      = 32'h9d2c_5680;
  localparam logic [31:0] MASK_C      = 32'hefc6_0000;

  localparam int RUN_ITEMS   = 490;  // draws per random phase
  localparam int RESTART_ODD = 250;  // one restart in this many random draws

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_restart = 1'b0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] out_random_word;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [WORD_W-1:0] pwdata = '0;
  logic [WORD_W-1:0] prdata;
  logic              pready;

  // Draw requests waiting for the driver (restart flag per beat)
  bit                draw_queue[$];
  // Tempered words still owed by the block, oldest first
  logic [31:0]       words_due[$];

  int                send_gap_pct = 0;
  int                recv_stall_pct = 0;
  int                mismatches = 0;

  // Shadow generator state
  logic [31:0]       mt_words[0:MT_N-1];
  int unsigned       mt_pos;
  logic [31:0]       mt_key;

  always #5 clk = ~clk;

  mt19937_single_key_generator_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_random_word (out_random_word),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Rebuild the ring from the key: linear fill, key mix, index mix, force word 0.
  function automatic void seed_ring();
    logic [31:0] p;
    int          at;
    for (int k = 1; k < MT_N; k++) begin
      if (k == 1) mt_words[0] = LINEAR_BASE;
      p = mt_words[k-1];
      mt_words[k] = LINEAR_MUL * (p ^ (p >> 30)) + 32'(k);
    end
    at = 1;
    for (int n = 0; n < MT_N; n++) begin
      p = mt_words[at-1];
      mt_words[at] = (mt_words[at] ^ ((p ^ (p >> 30)) * KEY_MUL)) + mt_key;
      at++;
      if (at >= MT_N) begin
        mt_words[0] = mt_words[MT_N-1];
        at = 1;
      end
    end
    for (int n = 0; n < MT_N - 1; n++) begin
      p = mt_words[at-1];
      mt_words[at] = (mt_words[at] ^ ((p ^ (p >> 30)) * INDEX_MUL)) - 32'(at);
      at++;
      if (at >= MT_N) begin
        mt_words[0] = mt_words[MT_N-1];
        at = 1;
      end
    end
    mt_words[0] = TOP_BIT;
    mt_pos = MT_N;
  endfunction

  // Regenerate all words in place, in index order.
  function automatic void twist_ring();
    logic [31:0] y;
    for (int k = 0; k < MT_N; k++) begin
      y = (mt_words[k] & TOP_BIT) | (mt_words[(k + 1) % MT_N] & LOW_BITS);
      mt_words[k] = mt_words[(k + MT_M) % MT_N] ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'h0);
    end
    mt_pos = 0;
  endfunction

  // Tempered word that one draw beat yields.
  function automatic logic [31:0] draw_word(input bit restart);
    logic [31:0] w;
    if (restart) seed_ring();
    if (mt_pos >= MT_N) twist_ring();
    w = mt_words[mt_pos];
    mt_pos++;
    w = w ^ (w >> 11);
    w = w ^ ((w << 7) & MASK_B);
    w = w ^ ((w << 15) & MASK_C);
    w = w ^ (w >> 18);
    return w;
  endfunction

  // Driver: on an accepted beat, predict its word; load the next beat only once the
  // current one is gone, so a stalled beat holds. Gaps are rolled independently of stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) words_due.push_back(draw_word(in_restart));
      if (!in_valid || !in_stall) begin
        if (draw_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid   <= 1'b1;
          in_restart <= draw_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted word against the oldest owed one, then roll the stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          report_mismatch("word with nothing owed", out_random_word, 'x);
        end else begin
          if (out_random_word !== words_due[0])
            report_mismatch("random_word", out_random_word, words_due[0]);
          void'(words_due.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Hold until every queued beat is taken and every owed word has come back.
  // Sample between edges so the driver's and monitor's updates have landed.
  task automatic drain();
    while (draw_queue.size() != 0 || in_valid) @(negedge clk);
    while (words_due.size() != 0) @(negedge clk);
    // every beat returns a word, so a short settle is plenty before touching config
    repeat (4) @(posedge clk);
  endtask

  // Write the seed key (setup, then access), read it back, and track it in the shadow.
  task automatic load_seed_key(input logic [31:0] key);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_SEED_KEY;
    pwdata  <= key;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mt_key = key;
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== mt_key) report_mismatch("seed_key readback", prdata, mt_key);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Ample headroom over the slowest correct run (restart seeding dominates).
  initial begin
    #(10_000_000);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    logic [31:0] phase_keys[4];
    int          gap_of[4];
    int          stall_of[4];

    phase_keys = '{32'hffff_ffff, $urandom, 32'h0000_0000, $urandom};
    gap_of     = '{0, 47, 0, 32};
    stall_of   = '{0, 0, 47, 32};

    // Reset builds the state from a zero key.
    mt_key = '0;
    seed_ring();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: plain draws off the reset state (the first one regenerates).
    draw_queue = '{1'b0, 1'b0, 1'b0};
    drain();
    // A new key alone must not disturb the running sequence; a restart picks it up.
    load_seed_key(32'hffff_ffff);
    draw_queue = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
    drain();
    load_seed_key(32'h0000_0000);
    draw_queue = '{1'b1, 1'b0, 1'b0};
    drain();
    load_seed_key(32'h8000_0000);
    draw_queue = '{1'b0, 1'b1, 1'b0};
    drain();

    // Random phases: long restart-free runs cross the 624-word boundary, and
    // occasional restarts land at arbitrary positions in the sequence.
    for (int ph = 0; ph < 4; ph++) begin
      load_seed_key(phase_keys[ph]);
      send_gap_pct   = gap_of[ph];
      recv_stall_pct = stall_of[ph];
      // restart at the head of odd phases only, so even phases keep the old stream going
      if (ph % 2 == 1) draw_queue.push_back(1'b1);
      for (int i = 0; i < RUN_ITEMS; i++)
        draw_queue.push_back($urandom_range(RESTART_ODD - 1) == 0);
      drain();
    end

    // Catch any stray word past the last owed one.
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);
    if (words_due.size() != 0) report_mismatch("words never returned", '0, words_due.size());

    if (mismatches == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
